### sv/okv_pkg.sv
// shared constants, codes and result type for the ordered key/value table
package okv_pkg;

  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_KEY_BITS = 64;

  localparam int MODE_W   = 3;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SORT   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic [STATUS_W-1:0]     status;
  } res_t;

endpackage

### sv/okv_mem.sv
// entry memory: one key/value pair per word, one write and one registered read per cycle
module okv_mem #(
  parameter int ENTRIES  = okv_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = okv_pkg::DEF_KEY_BITS
) (
  input  logic                               clk,
  input  logic                               rd_en,
  input  logic [$clog2(ENTRIES)-1:0]         rd_addr,
  output logic [KEY_BITS-1:0]                rd_key,
  output logic signed [okv_pkg::VAL_W-1:0]   rd_val,
  input  logic                               wr_en,
  input  logic [$clog2(ENTRIES)-1:0]         wr_addr,
  input  logic [KEY_BITS-1:0]                wr_key,
  input  logic signed [okv_pkg::VAL_W-1:0]   wr_val
);
  import okv_pkg::*;

  logic [KEY_BITS+VAL_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_key, wr_val};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_key, rd_val} <= mem[rd_addr];
    end
  end

endmodule

### sv/okv_ctrl.sv
// sequencer: scan, insert, delete with shift-down, and stable insertion sort over the memory
module okv_ctrl #(
  parameter int ENTRIES  = okv_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = okv_pkg::DEF_KEY_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [okv_pkg::MODE_W-1:0]         mode,
  input  logic [KEY_BITS-1:0]                key,
  input  logic signed [okv_pkg::VAL_W-1:0]   value,
  input  logic                               take,
  output logic                               idle,
  output logic                               done,
  output okv_pkg::res_t                      res,
  output logic [$clog2(ENTRIES+1)-1:0]       count
);
  import okv_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_SLOAD = 3'd3;
  localparam logic [2:0] S_SHOLD = 3'd4;
  localparam logic [2:0] S_SCMP  = 3'd5;
  localparam logic [2:0] S_SPUT  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]              state, state_next;
  logic [CW-1:0]           idx, pend_addr, si, sj;
  logic                    pend;
  logic [MODE_W-1:0]       mode_r;
  logic [KEY_BITS-1:0]     key_r, hold_key;
  logic signed [VAL_W-1:0] val_r, hold_val;

  logic                    rd_en, wr_en;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic [KEY_BITS-1:0]     rd_key, wr_key;
  logic signed [VAL_W-1:0] rd_val, wr_val;

  logic                    match, last, miss, less;
  logic [CW-1:0]           pend_prev, pend_nxt, sj_m1, sj_m2, si_m1, si_p1;

  okv_mem #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_val  (rd_val),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_val  (wr_val)
  );

  assign pend_prev = pend_addr - CW'(1);
  assign pend_nxt  = pend_addr + CW'(1);
  assign sj_m1     = sj - CW'(1);
  assign sj_m2     = sj - CW'(2);
  assign si_m1     = si - CW'(1);
  assign si_p1     = si + CW'(1);

  // read data is registered: valid in the cycle after its read was issued
  assign match = pend && (rd_key == key_r);
  assign last  = pend && (pend_nxt == count);
  assign miss  = (count == '0) || (last && !match);
  assign less  = rd_val < hold_val;

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_key  = rd_key;
    wr_val  = rd_val;
    case (state)
      S_SCAN: begin
        rd_en   = (idx != count);
        rd_addr = idx[AW-1:0];
        // append on a miss when there is room
        if (mode_r == MODE_INSERT && miss && count != CW'(ENTRIES)) begin
          wr_en   = 1'b1;
          wr_addr = count[AW-1:0];
          wr_key  = key_r;
          wr_val  = val_r;
        end
      end
      S_SHIFT: begin
        rd_en   = (idx != count);
        rd_addr = idx[AW-1:0];
        wr_en   = pend;
        wr_addr = pend_prev[AW-1:0];
      end
      S_SLOAD: begin
        rd_en   = 1'b1;
        rd_addr = si[AW-1:0];
      end
      S_SHOLD: begin
        rd_en   = 1'b1;
        rd_addr = si_m1[AW-1:0];
      end
      S_SCMP: begin
        wr_en   = 1'b1;
        wr_addr = sj[AW-1:0];
        if (less) begin
          // move the lower entry up and look one further down
          rd_en   = (sj != CW'(1));
          rd_addr = sj_m2[AW-1:0];
        end else begin
          wr_key = hold_key;
          wr_val = hold_val;
        end
      end
      S_SPUT: begin
        wr_en   = 1'b1;
        wr_addr = sj[AW-1:0];
        wr_key  = hold_key;
        wr_val  = hold_val;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (mode) inside
            MODE_INSERT, MODE_DELETE, MODE_LOOKUP: state_next = S_SCAN;
            MODE_SORT: state_next = (count < CW'(2)) ? S_DONE : S_SLOAD;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (match) begin
          state_next = (mode_r == MODE_DELETE && !last) ? S_SHIFT : S_DONE;
        end else if (miss) begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        if (last) begin
          state_next = S_DONE;
        end
      end
      S_SLOAD: state_next = S_SHOLD;
      S_SHOLD: state_next = S_SCMP;
      S_SCMP: begin
        if (less) begin
          state_next = (sj == CW'(1)) ? S_SPUT : S_SCMP;
        end else begin
          state_next = (si_p1 == count) ? S_DONE : S_SLOAD;
        end
      end
      S_SPUT: state_next = (si_p1 == count) ? S_DONE : S_SLOAD;
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            mode_r <= mode;
            key_r  <= key;
            val_r  <= value;
            res    <= '{found: 1'b0, read_value: '0, status: ST_OK};
            idx    <= '0;
            pend   <= 1'b0;
            si     <= CW'(1);
            if (mode == MODE_CLEAR) begin
              count <= '0;
            end
          end
        end
        S_SCAN: begin
          pend      <= rd_en;
          pend_addr <= idx;
          if (rd_en) begin
            idx <= idx + CW'(1);
          end
          if (match) begin
            res.found <= 1'b1;
            case (mode_r)
              MODE_LOOKUP: res.read_value <= rd_val;
              MODE_INSERT: res.status <= ST_DUP;
              default: begin
                // delete: close the gap from the next position on
                idx  <= pend_nxt;
                pend <= 1'b0;
                if (last) begin
                  count <= count - CW'(1);
                end
              end
            endcase
          end else if (miss) begin
            if (mode_r == MODE_INSERT) begin
              if (count == CW'(ENTRIES)) begin
                res.status <= ST_FULL;
              end else begin
                count <= count + CW'(1);
              end
            end else begin
              res.status <= ST_ABSENT;
            end
          end
        end
        S_SHIFT: begin
          pend      <= rd_en;
          pend_addr <= idx;
          if (rd_en) begin
            idx <= idx + CW'(1);
          end
          if (last) begin
            count <= count - CW'(1);
          end
        end
        S_SHOLD: begin
          hold_key <= rd_key;
          hold_val <= rd_val;
          sj       <= si;
        end
        S_SCMP: begin
          if (less) begin
            sj <= sj_m1;
          end else begin
            si <= si_p1;
          end
        end
        S_SPUT: si <= si_p1;
        default: begin
        end
      endcase
    end
  end

endmodule

### sv/ordered_key_value_table.sv
// ordered key/value table top level: stream ports, item decode and result register
//
//  channel  | dir | contents
//  ---------+-----+------------------------------------------------------
//  s_axis   | in  | mode, key, value (one operation per item)
//  m_axis   | out | found, read_value, entries_used, is_empty, is_full, status
//
// clear empties the table; insert, delete and lookup walk the table over
// the stored pairs, and a delete hit shifts later pairs down
// sort runs an insertion sort through the single-read-port memory;
// one item is in work at a time
// rst clears the fill count and the handshake; memory contents are not cleared
// a finished result waits in the output register; the next item is taken meanwhile
module ordered_key_value_table #(
  parameter int ENTRIES  = okv_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = okv_pkg::DEF_KEY_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [2:0] mode, [66:3] key, [98:67] value, [103:99] zero
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // found, read_value, entries_used, is_empty, is_full, status, zero fill
  output logic [((37 + $clog2(ENTRIES + 1) + 7) / 8) * 8 - 1:0] m_tdata
);
  import okv_pkg::*;

  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int OUT_W = ((37 + CW + 7) / 8) * 8;
  localparam int PAD_W = OUT_W - (37 + CW);

  logic [MODE_W-1:0]       in_mode;
  logic [KEY_W-1:0]        in_key;
  logic signed [VAL_W-1:0] in_value;
  logic                    start, take, idle, done;
  res_t                    res;
  logic [CW-1:0]           count;

  assign in_mode  = s_tdata[MODE_W-1:0];
  assign in_key   = s_tdata[MODE_W+KEY_W-1:MODE_W];
  assign in_value = s_tdata[MODE_W+KEY_W+VAL_W-1:MODE_W+KEY_W];

  assign s_tready = idle;
  assign start    = s_tvalid && idle;
  assign take     = done && (!m_tvalid || m_tready);

  okv_ctrl #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (in_mode),
    .key   (in_key[KEY_BITS-1:0]),
    .value (in_value),
    .take  (take),
    .idle  (idle),
    .done  (done),
    .res   (res),
    .count (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // fill level is final by the time the sequencer reports done
  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {{PAD_W{1'b0}}, res.status, (count == CW'(ENTRIES)), (count == '0),
                  count, res.read_value, res.found};
    end
  end

endmodule
